// ===== src/gradient_color_ramp_lookup_defines.svh =====
// Assertion macros used by the gradient color ramp checker.
`ifndef GRADIENT_COLOR_RAMP_LOOKUP_DEFINES_SVH
`define GRADIENT_COLOR_RAMP_LOOKUP_DEFINES_SVH

// Checks that post holds in the same cycle whenever pre holds.
`define GRCL_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("grcl implication check failed");

// Checks that post holds after pre, delayed by the n argument.
`define GRCL_ASSERT_AFTER(label, clk, rst_n, pre, n, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> ##n (post)) \
		else $error("grcl delayed check failed");

`endif

// ===== src/grcl_pkg.sv =====
// Types and constants of the gradient color ramp lookup.
`default_nettype none

package grcl_pkg;

	localparam int MAX_STOPS    = 4;
	localparam int STOP_REGS    = 4;
	localparam int POS_BITS     = 16;
	localparam int FRAC_BITS    = 16;
	localparam int QUO_BITS     = POS_BITS + FRAC_BITS;
	localparam int STOP_IDX_W   = $clog2(STOP_REGS);
	localparam int STOP_FIELD_W = 16;
	localparam int POSITION_W   = 16;
	localparam int COUNT_W      = 3;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 64;
	localparam int COLOR_W      = 32;
	localparam int CH_W         = 8;
	localparam int NUM_CH       = 4;
	localparam int PROD_Q_W     = FRAC_BITS + CH_W;
	localparam int PROD_W       = PROD_Q_W + CH_W;
	// Front register, one register per divider cell, product and output registers.
	localparam int LATENCY      = QUO_BITS + 3;

	localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_STOP_POSITIONS = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_STOP_COLOR_0   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_STOP_COLOR_1   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_STOP_COLOR_2   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_STOP_COLOR_3   = CFG_IDX_W'(5);

	localparam logic [COUNT_W-1:0]    RESET_STOP_COUNT     = COUNT_W'(2);
	localparam logic [CFG_DATA_W-1:0] RESET_STOP_POSITIONS = 64'h0000_0000_FFFF_0000;
	localparam logic [COLOR_W-1:0]    RESET_COLOR_0        = 32'h0000_0000;
	localparam logic [COLOR_W-1:0]    RESET_COLOR_1        = 32'hFFFF_FFFF;
	localparam logic [COLOR_W-1:0]    RESET_COLOR_2        = 32'h0000_0000;
	localparam logic [COLOR_W-1:0]    RESET_COLOR_3        = 32'h0000_0000;

	typedef struct packed {
		logic                bad;
		logic [POS_BITS-1:0] rem;
		logic [POS_BITS-1:0] num;
		logic [POS_BITS-1:0] span;
		logic [QUO_BITS-1:0] quo;
		logic [COLOR_W-1:0]  c_lo;
		logic [COLOR_W-1:0]  c_hi;
	} grcl_div_t;

	typedef struct packed {
		logic      valid;
		grcl_div_t data;
	} grcl_stage_t;

endpackage

`default_nettype wire

// ===== src/grcl_select.sv =====
// Front stage: picks the lower and upper stops and forms the span and offset.
`default_nettype none

module grcl_select (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic [grcl_pkg::POSITION_W-1:0]      position,
	input  logic [grcl_pkg::COUNT_W-1:0]         stop_count,
	input  logic [grcl_pkg::CFG_DATA_W-1:0]      stop_positions,
	input  logic [grcl_pkg::COLOR_W-1:0]         stop_color [grcl_pkg::STOP_REGS],
	output grcl_pkg::grcl_stage_t                stage
);
	import grcl_pkg::*;

	logic [POS_BITS-1:0]   x;
	logic [POS_BITS-1:0]   pos [MAX_STOPS];
	logic [POS_BITS-1:0]   p_lo;
	logic [POS_BITS-1:0]   p_hi;
	logic [COUNT_W-1:0]    n;
	logic [STOP_IDX_W-1:0] lo;
	logic [STOP_IDX_W-1:0] hi;
	logic                  found;
	logic                  bad;
	logic                  valid_s1;
	grcl_div_t             data_s1;

	always_comb begin
		for (int i = 0; i < MAX_STOPS; i++) begin
			pos[i] = stop_positions[STOP_FIELD_W*i +: POS_BITS];
		end
		x = position[POS_BITS-1:0];
		n = (stop_count > COUNT_W'(MAX_STOPS)) ? COUNT_W'(MAX_STOPS) : stop_count;
		lo = '0;
		hi = '0;
		found = 1'b0;
		// The scan ends at the first stop above x; stops after it do not move lo.
		for (int i = 0; i < MAX_STOPS; i++) begin
			if ((COUNT_W'(i) < n) && !found) begin
				if (pos[i] < x) begin
					lo = STOP_IDX_W'(i);
				end
				if (pos[i] > x) begin
					hi = STOP_IDX_W'(i);
					found = 1'b1;
				end
			end
		end
		// Full scale always interpolates toward the last stop in use.
		if ((x == '1) && (n != '0)) begin
			hi = STOP_IDX_W'(n - COUNT_W'(1));
		end
		p_lo = pos[lo];
		p_hi = pos[hi];
		bad = (n == '0) || (p_hi <= p_lo) || (x < p_lo);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1.bad  <= bad;
			data_s1.rem  <= '0;
			data_s1.num  <= x - p_lo;
			data_s1.span <= p_hi - p_lo;
			data_s1.quo  <= '0;
			data_s1.c_lo <= stop_color[lo];
			data_s1.c_hi <= stop_color[hi];
		end
	end

	assign stage = '{valid: valid_s1, data: data_s1};

endmodule

`default_nettype wire

// ===== src/grcl_div_cell.sv =====
// One divider cell: resolves one quotient bit and passes the word to the next cell.
`default_nettype none

module grcl_div_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  grcl_pkg::grcl_stage_t din,
	output grcl_pkg::grcl_stage_t dout
);
	import grcl_pkg::*;

	logic [POS_BITS:0] r;
	logic [POS_BITS:0] diff;
	logic              ge;
	grcl_div_t         nxt;
	logic              valid_s1;
	grcl_div_t         data_s1;

	always_comb begin
		r = {din.data.rem, din.data.num[POS_BITS-1]};
		diff = r - {1'b0, din.data.span};
		ge = (r >= {1'b0, din.data.span});
		nxt = din.data;
		// The remainder stays below the span, so it fits the narrower field.
		nxt.rem = ge ? diff[POS_BITS-1:0] : r[POS_BITS-1:0];
		nxt.num = {din.data.num[POS_BITS-2:0], 1'b0};
		nxt.quo = {din.data.quo[QUO_BITS-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid) begin
			data_s1 <= nxt;
		end
	end

	assign dout = '{valid: valid_s1, data: data_s1};

endmodule

`default_nettype wire

// ===== src/grcl_mix.sv =====
// Output stages: scales each channel difference by the quotient and adds it to, or subtracts it from, the lower color.
`default_nettype none

module grcl_mix (
	input  logic                         clk,
	input  logic                         arst_n,
	input  grcl_pkg::grcl_stage_t        din,
	output logic                         done,
	output logic [grcl_pkg::CH_W-1:0]    red,
	output logic [grcl_pkg::CH_W-1:0]    green,
	output logic [grcl_pkg::CH_W-1:0]    blue,
	output logic [grcl_pkg::CH_W-1:0]    alpha,
	output logic                         bad_span
);
	import grcl_pkg::*;

	logic [CH_W-1:0]   cl   [NUM_CH];
	logic [CH_W-1:0]   chv  [NUM_CH];
	logic [CH_W-1:0]   mag  [NUM_CH];
	logic              neg  [NUM_CH];
	logic [PROD_W-1:0] prod [NUM_CH];
	logic [CH_W-1:0]   sum  [NUM_CH];

	logic              valid_s1;
	logic              bad_s1;
	logic [CH_W-1:0]   lo_s1  [NUM_CH];
	logic [CH_W-1:0]   t_s1   [NUM_CH];
	logic              neg_s1 [NUM_CH];

	logic              done_s2;
	logic              bad_s2;
	logic [CH_W-1:0]   color_s2 [NUM_CH];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			cl[c]  = din.data.c_lo[CH_W*c +: CH_W];
			chv[c] = din.data.c_hi[CH_W*c +: CH_W];
			neg[c] = chv[c] < cl[c];
			mag[c] = neg[c] ? (cl[c] - chv[c]) : (chv[c] - cl[c]);
			// Only the low eight bits of the scaled difference survive the wrap,
			// so the quotient bits above them are not needed.
			prod[c] = PROD_W'(mag[c]) * PROD_W'(din.data.quo[PROD_Q_W-1:0]);
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			sum[c] = neg_s1[c] ? (lo_s1[c] - t_s1[c]) : (lo_s1[c] + t_s1[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= din.valid;
			done_s2  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid) begin
			bad_s1 <= din.data.bad;
			for (int c = 0; c < NUM_CH; c++) begin
				lo_s1[c]  <= cl[c];
				t_s1[c]   <= prod[c][FRAC_BITS +: CH_W];
				neg_s1[c] <= neg[c];
			end
		end
		if (valid_s1) begin
			bad_s2 <= bad_s1;
			for (int c = 0; c < NUM_CH; c++) begin
				color_s2[c] <= bad_s1 ? '0 : sum[c];
			end
		end
	end

	assign done     = done_s2;
	assign bad_span = bad_s2;
	assign red      = color_s2[0];
	assign green    = color_s2[1];
	assign blue     = color_s2[2];
	assign alpha    = color_s2[3];

endmodule

`default_nettype wire

// ===== src/gradient_color_ramp_lookup.sv =====
// Top level of the gradient color ramp lookup.
`default_nettype none
// Maps a 16-bit position (65535 is 1.0) to an RGBA color between up to four stops.
// Input: a position word is taken at each rising edge with start high and busy low.
// busy stays low, so a new position can be issued in every cycle.
// Output: done is high for one cycle with red, green, blue, alpha and bad_span;
// the receiver cannot hold results off and none is needed, since every stage
// advances on every cycle.
// Pipeline: a front register holds the selected stops, a chain of 32 divider
// cells resolves one quotient bit each, then a product register holds the scaled
// channel differences and an output register the result combined with the lower color.
// Throughput: one position per cycle, set by the divider chain moving one word
// per cell per cycle.
// Configuration: cfg_ready is always high; a word is written when cfg_valid is
// high. Write only while no position is in flight. Unused indexes are ignored.
// Reset: clears all stage valid bits and loads the register reset values.
module gradient_color_ramp_lookup (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [grcl_pkg::POSITION_W-1:0]   position,
	output logic                              done,
	output logic [grcl_pkg::CH_W-1:0]         red,
	output logic [grcl_pkg::CH_W-1:0]         green,
	output logic [grcl_pkg::CH_W-1:0]         blue,
	output logic [grcl_pkg::CH_W-1:0]         alpha,
	output logic                              bad_span,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [grcl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [grcl_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import grcl_pkg::*;

	logic [COUNT_W-1:0]    stop_count_q;
	logic [CFG_DATA_W-1:0] stop_positions_q;
	logic [COLOR_W-1:0]    stop_color_q [STOP_REGS];
	logic                  accept;
	grcl_stage_t           chain [QUO_BITS+1];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_count_q     <= RESET_STOP_COUNT;
			stop_positions_q <= RESET_STOP_POSITIONS;
			stop_color_q[0]  <= RESET_COLOR_0;
			stop_color_q[1]  <= RESET_COLOR_1;
			stop_color_q[2]  <= RESET_COLOR_2;
			stop_color_q[3]  <= RESET_COLOR_3;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STOP_COUNT: begin
					stop_count_q <= cfg_data[COUNT_W-1:0];
				end
				REG_STOP_POSITIONS: begin
					stop_positions_q <= cfg_data;
				end
				REG_STOP_COLOR_0: begin
					stop_color_q[0] <= cfg_data[COLOR_W-1:0];
				end
				REG_STOP_COLOR_1: begin
					stop_color_q[1] <= cfg_data[COLOR_W-1:0];
				end
				REG_STOP_COLOR_2: begin
					stop_color_q[2] <= cfg_data[COLOR_W-1:0];
				end
				REG_STOP_COLOR_3: begin
					stop_color_q[3] <= cfg_data[COLOR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	grcl_select u_select (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.position       (position),
		.stop_count     (stop_count_q),
		.stop_positions (stop_positions_q),
		.stop_color     (stop_color_q),
		.stage          (chain[0])
	);

	for (genvar k = 0; k < QUO_BITS; k++) begin : g_cell
		grcl_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (chain[k]),
			.dout   (chain[k+1])
		);
	end

	grcl_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.din      (chain[QUO_BITS]),
		.done     (done),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.alpha    (alpha),
		.bad_span (bad_span)
	);

endmodule

`default_nettype wire

// ===== src/grcl_checker.sv =====
// Port-level checker for the gradient color ramp lookup and its bind.
`default_nettype none
`include "gradient_color_ramp_lookup_defines.svh"

module grcl_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic [grcl_pkg::CH_W-1:0]      red,
	input logic [grcl_pkg::CH_W-1:0]      green,
	input logic [grcl_pkg::CH_W-1:0]      blue,
	input logic [grcl_pkg::CH_W-1:0]      alpha,
	input logic                           bad_span
);
	import grcl_pkg::*;

	// Every accepted position produces a result after the fixed pipeline depth.
	`GRCL_ASSERT_AFTER(a_accept_gives_done, clk, arst_n, start && !busy, LATENCY, done)
	// No result appears without a position accepted the pipeline depth earlier.
	`GRCL_ASSERT_IMPLY(a_done_from_accept, clk, arst_n, done, $past(start && !busy, LATENCY))
	// A result flagged as a bad span carries a black, transparent color.
	`GRCL_ASSERT_IMPLY(a_bad_is_zero, clk, arst_n, done && bad_span, (red == '0) && (green == '0) && (blue == '0) && (alpha == '0))

endmodule

bind gradient_color_ramp_lookup grcl_checker u_grcl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.red      (red),
	.green    (green),
	.blue     (blue),
	.alpha    (alpha),
	.bad_span (bad_span)
);

`default_nettype wire
